>>> hdl/assert_macros.svh
// assertion helpers, all sampled on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RLT_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rlt assertion failed");

// next-cycle implication
`define RLT_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rlt assertion failed");

`endif

>>> hdl/rlt_pkg.sv
package rlt_pkg;

	localparam int BUFFER_BYTES_DEF = 10;
	localparam int QUEUE_DEPTH      = 2;

	localparam int BYTE_W    = 8;
	localparam int CODE_W    = 4;
	localparam int LEN_W     = 4;
	localparam int MAX_CODES = 8;
	localparam int CHARS_W   = CODE_W * MAX_CODES;

	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3f;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

	localparam logic [CODE_W-1:0] CODE_DOT   = 4'd10;
	localparam logic [CODE_W-1:0] CODE_MINUS = 4'd11;

	typedef enum logic [2:0] {
		CLS_EOL,
		CLS_HASH,
		CLS_QMARK,
		CLS_SPACE,
		CLS_COMMA,
		CLS_NUM,
		CLS_OTHER
	} tok_cls_t;

	typedef struct packed {
		tok_cls_t            cls;
		logic [CODE_W-1:0]   code;
	} tok_t;

	typedef struct packed {
		logic [LEN_W-1:0]    first_length;
		logic [CHARS_W-1:0]  first_codes;
		logic                has_second;
		logic [LEN_W-1:0]    second_length;
		logic [CHARS_W-1:0]  second_codes;
	} result_t;

endpackage

>>> hdl/rlt_fifo.sv
module rlt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	// depth is a power of two so the pointers wrap by themselves
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

>>> hdl/rlt_front.sv
module rlt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [rlt_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        tok_valid,
	output rlt_pkg::tok_t               tok,
	input  logic                        tok_take
);
	import rlt_pkg::*;

	tok_t tok_d;
	logic tok_empty;
	logic [$bits(tok_t)-1:0] tok_bits;

	always_comb begin
		tok_d.code = '0;
		case (rx_byte) inside
			CH_CR, CH_LF: tok_d.cls = CLS_EOL;
			CH_HASH:      tok_d.cls = CLS_HASH;
			CH_QMARK:     tok_d.cls = CLS_QMARK;
			CH_SPACE:     tok_d.cls = CLS_SPACE;
			CH_COMMA:     tok_d.cls = CLS_COMMA;
			CH_DOT: begin
				tok_d.cls  = CLS_NUM;
				tok_d.code = CODE_DOT;
			end
			CH_MINUS: begin
				tok_d.cls  = CLS_NUM;
				tok_d.code = CODE_MINUS;
			end
			[CH_0:CH_9]: begin
				tok_d.cls  = CLS_NUM;
				tok_d.code = CODE_W'(rx_byte - CH_0);
			end
			default:      tok_d.cls = CLS_OTHER;
		endcase
	end

	rlt_fifo #(
		.WIDTH ($bits(tok_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (tok_d),
		.full   (full),
		.pop    (tok_take),
		.dout   (tok_bits),
		.empty  (tok_empty)
	);

	assign tok       = tok_t'(tok_bits);
	assign tok_valid = ~tok_empty;

endmodule

>>> hdl/rlt_back.sv
`include "assert_macros.svh"

module rlt_back #(
	parameter int BUFFER_BYTES = rlt_pkg::BUFFER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	input  rlt_pkg::tok_t     tok,
	output logic              tok_take,
	output logic              res_empty,
	output rlt_pkg::result_t  res,
	input  logic              res_pop
);
	import rlt_pkg::*;

	localparam logic [LEN_W:0] LIMIT = (LEN_W+1)'(BUFFER_BYTES - 1);

	logic                discard_q;
	logic                skip_q;
	logic                idx_q;
	logic [LEN_W-1:0]    len_q   [2];
	logic [CHARS_W-1:0]  chars_q [2];

	logic                discard_d;
	logic                skip_d;
	logic                idx_d;
	logic [LEN_W-1:0]    len_d   [2];
	logic [CHARS_W-1:0]  chars_d [2];

	logic                res_full;
	logic                res_push;
	result_t             res_d;
	logic [$bits(result_t)-1:0] res_bits;
	logic [LEN_W-1:0]    pos;
	logic [LEN_W:0]      next_len;

	assign tok_take = tok_valid & ~res_full;
	assign pos      = len_q[idx_q];
	assign next_len = {1'b0, pos} + (LEN_W+1)'(1);

	assign res_d.first_length  = len_q[0];
	assign res_d.first_codes   = chars_q[0];
	assign res_d.has_second    = idx_q;
	assign res_d.second_length = len_q[1];
	assign res_d.second_codes  = chars_q[1];

	always_comb begin
		discard_d = discard_q;
		skip_d    = skip_q;
		idx_d     = idx_q;
		len_d     = len_q;
		chars_d   = chars_q;
		res_push  = 1'b0;
		if (tok_take) begin
			if (tok.cls == CLS_EOL) begin
				res_push  = (len_q[0] != '0);
				discard_d = 1'b0;
				skip_d    = 1'b0;
				idx_d     = 1'b0;
				len_d     = '{default: '0};
				chars_d   = '{default: '0};
			end else if (tok.cls == CLS_HASH || discard_q) begin
				discard_d = 1'b1;
			end else if (tok.cls == CLS_QMARK) begin
				skip_d = 1'b1;
			end else if (skip_q) begin
				if (tok.cls == CLS_SPACE) begin
					skip_d = 1'b0;
				end
			end else if (tok.cls == CLS_COMMA) begin
				if (!idx_q && len_q[0] != '0) begin
					idx_d = 1'b1;
				end else begin
					// empty first field or a third field
					discard_d = 1'b1;
					idx_d     = 1'b0;
					len_d     = '{default: '0};
					chars_d   = '{default: '0};
				end
			end else if (tok.cls == CLS_NUM) begin
				if (!pos[LEN_W-1]) begin
					chars_d[idx_q][{pos[LEN_W-2:0], 2'b00} +: CODE_W] = tok.code;
				end
				len_d[idx_q] = next_len[LEN_W-1:0];
				if (next_len >= LIMIT) begin
					// field too long for the buffer
					discard_d = 1'b1;
					idx_d     = 1'b0;
					len_d     = '{default: '0};
					chars_d   = '{default: '0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discard_q <= 1'b0;
			skip_q    <= 1'b0;
			idx_q     <= 1'b0;
			len_q     <= '{default: '0};
			chars_q   <= '{default: '0};
		end else begin
			discard_q <= discard_d;
			skip_q    <= skip_d;
			idx_q     <= idx_d;
			len_q     <= len_d;
			chars_q   <= chars_d;
		end
	end

	rlt_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_d),
		.full   (res_full),
		.pop    (res_pop),
		.dout   (res_bits),
		.empty  (res_empty)
	);

	assign res = result_t'(res_bits);

	`RLT_ASSERT_NEXT(a_eol_clears, tok_take && tok.cls == CLS_EOL, len_q[0] == '0 && len_q[1] == '0 && !idx_q && !discard_q && !skip_q)
	`RLT_ASSERT_IMP(a_len_bound, 1'b1, (LEN_W+1)'(len_q[0]) < LIMIT && (LEN_W+1)'(len_q[1]) < LIMIT)
	`RLT_ASSERT_IMP(a_second_closed, !idx_q, len_q[1] == '0 && chars_q[1] == '0)
	`RLT_ASSERT_IMP(a_emit_ok, res_push, !res_full && res_d.first_length != '0)

endmodule

>>> hdl/reply_line_tokenizer_top.sv
// Splits a received text stream into lines of up to two comma separated numeric fields and
// queues one result per line whose first field is not empty. One byte is taken every clock
// while the small token queue has room; the back end updates the field state once per byte,
// which sets the sustained rate of one byte per clock while the result queue has room. A result
// appears on the output queue in the cycle after its end-of-line byte was taken. Both sides
// stall on their own: full rises only when the token queue backs up behind an unread result queue.
module reply_line_tokenizer_top #(
	parameter int BUFFER_BYTES = rlt_pkg::BUFFER_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [rlt_pkg::BYTE_W-1:0]   rx_byte,
	output logic                         empty,
	input  logic                         pop,
	output logic [rlt_pkg::LEN_W-1:0]    first_length,
	output logic [rlt_pkg::CHARS_W-1:0]  first_codes,
	output logic                         has_second,
	output logic [rlt_pkg::LEN_W-1:0]    second_length,
	output logic [rlt_pkg::CHARS_W-1:0]  second_codes
);
	import rlt_pkg::*;

	tok_t    tok;
	logic    tok_valid;
	logic    tok_take;
	result_t res;

	rlt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_take  (tok_take)
	);

	rlt_back #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_take  (tok_take),
		.res_empty (empty),
		.res       (res),
		.res_pop   (pop)
	);

	assign first_length  = res.first_length;
	assign first_codes   = res.first_codes;
	assign has_second    = res.has_second;
	assign second_length = res.second_length;
	assign second_codes  = res.second_codes;

endmodule

>>> test/reply_line_tokenizer_checker.sv
module reply_line_tokenizer_checker
	import rlt_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic [BYTE_W-1:0]   rx_byte,
	input  logic                empty,
	input  logic                pop,
	input  logic [LEN_W-1:0]    first_length,
	input  logic [CHARS_W-1:0]  first_codes,
	input  logic                has_second,
	input  logic [LEN_W-1:0]    second_length,
	input  logic [CHARS_W-1:0]  second_codes,
	output int                  fail_count,
	output int                  pending
);

	logic               discard_line = 1'b0;
	logic               skip_to_space = 1'b0;
	logic               field_index = 1'b0;
	logic [LEN_W-1:0]   field_len [2] = '{default: '0};
	logic [CHARS_W-1:0] field_codes [2] = '{default: '0};

	result_t lines_due [$];
	int      failures = 0;
	int      due_count = 0;

	assign fail_count = failures;
	assign pending    = due_count;

	task automatic clear_fields();
		field_len[0]   = '0;
		field_len[1]   = '0;
		field_codes[0] = '0;
		field_codes[1] = '0;
		field_index    = 1'b0;
	endtask

	// one received byte through the line state, queueing a result on end of line if the first field is not empty
	task automatic tokenize(input logic [BYTE_W-1:0] c);
		result_t           line;
		logic [CODE_W-1:0] code;
		int                k;
		int                pos;
		if (c == CH_CR || c == CH_LF) begin
			if (field_len[0] != 0) begin
				line.first_length  = field_len[0];
				line.first_codes   = field_codes[0];
				line.has_second    = field_index;
				line.second_length = field_len[1];
				line.second_codes  = field_codes[1];
				lines_due.push_back(line);
			end
			clear_fields();
			discard_line  = 1'b0;
			skip_to_space = 1'b0;
		end else if (c == CH_HASH || discard_line) begin
			discard_line = 1'b1;
		end else if (c == CH_QMARK) begin
			skip_to_space = 1'b1;
		end else if (skip_to_space) begin
			if (c == CH_SPACE)
				skip_to_space = 1'b0;
		end else if (c == CH_COMMA) begin
			if (!field_index && field_len[0] != 0) begin
				field_index = 1'b1;
			end else begin
				clear_fields();
				discard_line = 1'b1;
			end
		end else if ((c >= CH_0 && c <= CH_9) || c == CH_DOT || c == CH_MINUS) begin
			k   = field_index;
			pos = field_len[k];
			if (c == CH_DOT)
				code = CODE_DOT;
			else if (c == CH_MINUS)
				code = CODE_MINUS;
			else
				code = CODE_W'(c - CH_0);
			// characters past the eighth still count but are not stored
			if (pos < MAX_CODES)
				field_codes[k][CODE_W*pos +: CODE_W] = code;
			field_len[k] = LEN_W'(pos + 1);
			if (pos + 1 >= BUFFER_BYTES - 1) begin
				clear_fields();
				discard_line = 1'b1;
			end
		end
	endtask

	task automatic compare_line();
		result_t want;
		if (lines_due.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected line result: len %0d codes %h second %0b len %0d codes %h",
					first_length, first_codes, has_second, second_length, second_codes);
		end else begin
			want = lines_due.pop_front();
			if (first_length !== want.first_length || first_codes !== want.first_codes ||
					has_second !== want.has_second || second_length !== want.second_length ||
					second_codes !== want.second_codes) begin
				failures++;
				if (failures <= 10) begin
					$display("line result mismatch: expected len %0d codes %h second %0b len %0d codes %h",
						want.first_length, want.first_codes, want.has_second,
						want.second_length, want.second_codes);
					$display("                      actual   len %0d codes %h second %0b len %0d codes %h",
						first_length, first_codes, has_second, second_length, second_codes);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_fields();
			discard_line  = 1'b0;
			skip_to_space = 1'b0;
			lines_due.delete();
			due_count = 0;
		end else begin
			if (push && !full)
				tokenize(rx_byte);
			if (pop && !empty)
				compare_line();
			due_count = lines_due.size();
		end
	end

endmodule

>>> test/reply_line_tokenizer_top_tb.sv
module reply_line_tokenizer_top_tb;
	import rlt_pkg::*;

	localparam int BUFFER_BYTES = BUFFER_BYTES_DEF;
	localparam int FIELD_MAX    = BUFFER_BYTES - 2;
	localparam int ITEM_TARGET  = 1600;
	localparam int CYCLE_LIMIT  = 400000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [BYTE_W-1:0]  rx_byte;
	logic               empty;
	logic               pop;
	logic [LEN_W-1:0]   first_length;
	logic [CHARS_W-1:0] first_codes;
	logic               has_second;
	logic [LEN_W-1:0]   second_length;
	logic [CHARS_W-1:0] second_codes;

	int fail_count;
	int pending;
	bit steady = 1'b0;
	int fed_count = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	reply_line_tokenizer_top #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.first_length(first_length),
		.first_codes(first_codes),
		.has_second(has_second),
		.second_length(second_length),
		.second_codes(second_codes)
	);

	reply_line_tokenizer_checker #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) line_check (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.first_length(first_length),
		.first_codes(first_codes),
		.has_second(has_second),
		.second_length(second_length),
		.second_codes(second_codes),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side stalls at random, never during the steady stretch
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			pop <= steady || $urandom_range(0, 99) >= 31;
		end
	end

	// a byte with no meaning to the line state
	function automatic logic [BYTE_W-1:0] noise_byte();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while (b == CH_CR || b == CH_LF || b == CH_HASH || b == CH_QMARK || b == CH_SPACE ||
			b == CH_COMMA || b == CH_DOT || b == CH_MINUS || (b >= CH_0 && b <= CH_9));
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] numeric_char();
		int r;
		r = $urandom_range(0, 11);
		if (r == 10)
			return CH_DOT;
		if (r == 11)
			return CH_MINUS;
		return CH_0 + BYTE_W'(r);
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (!steady && $urandom_range(0, 99) < 31) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (full);
		fed_count++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_field(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_byte(noise_byte());
			send_byte(numeric_char());
		end
	endtask

	task automatic send_eol();
		case ($urandom_range(0, 2))
			0: send_byte(CH_CR);
			1: send_byte(CH_LF);
			default: begin
				send_byte(CH_CR);
				send_byte(CH_LF);
			end
		endcase
	endtask

	initial begin
		int kind;
		arst_n  <= 1'b0;
		push    <= 1'b0;
		rx_byte <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full first field, one-character second field
		send_text("0123456-,.");
		send_byte(CH_CR);
		// comma with nothing before it
		send_text(",");
		send_byte(CH_LF);
		send_text("#9");
		send_byte(CH_LF);
		// query mark skips the high byte up to the space
		send_text("?");
		send_byte(8'hff);
		send_text(" 9");
		send_byte(CH_CR);
		// third field
		send_text("5,8,7");
		send_byte(CH_LF);

		while (fed_count < ITEM_TARGET) begin
			steady = fed_count >= 700 && fed_count < 1000;
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				if ($urandom_range(0, 9) == 0) begin
					send_byte(CH_QMARK);
					send_byte(noise_byte());
					send_field($urandom_range(0, 2));
					send_byte(CH_SPACE);
				end
				send_field(($urandom_range(0, 7) == 0) ? FIELD_MAX : $urandom_range(1, 5));
				if ($urandom_range(0, 1)) begin
					send_byte(CH_COMMA);
					send_field(($urandom_range(0, 7) == 0) ? FIELD_MAX : $urandom_range(0, 5));
				end
				send_eol();
			end else if (kind < 68) begin
				// over-long field in either position
				if ($urandom_range(0, 1)) begin
					send_field($urandom_range(1, 3));
					send_byte(CH_COMMA);
				end
				send_field($urandom_range(FIELD_MAX + 1, FIELD_MAX + 3));
				send_field($urandom_range(0, 2));
				send_eol();
			end else if (kind < 75) begin
				send_field($urandom_range(1, 3));
				send_byte(CH_COMMA);
				send_field($urandom_range(0, 3));
				send_byte(CH_COMMA);
				send_field($urandom_range(0, 3));
				send_eol();
			end else if (kind < 80) begin
				send_byte(CH_COMMA);
				send_field($urandom_range(0, 3));
				send_eol();
			end else if (kind < 87) begin
				send_field($urandom_range(0, 3));
				send_byte(CH_HASH);
				send_field($urandom_range(0, 4));
				if ($urandom_range(0, 1))
					send_byte(CH_COMMA);
				send_eol();
			end else if (kind < 93) begin
				send_field($urandom_range(0, 3));
				send_byte(CH_QMARK);
				repeat ($urandom_range(0, 4))
					send_byte($urandom_range(0, 1) ? numeric_char() : noise_byte());
				if ($urandom_range(0, 3) != 0)
					send_byte(CH_SPACE);
				send_field($urandom_range(1, 4));
				send_eol();
			end else begin
				repeat ($urandom_range(1, 12))
					send_byte(BYTE_W'($urandom_range(0, 255)));
				send_eol();
			end
		end
		push   <= 1'b0;
		steady = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
